// ===== hdl/ccr_pkg.sv =====
// Package with the types, constants and the linearization table of the contrast ratio block.
package ccr_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned RatioW    = FracBits + 5;
  localparam int unsigned LumW      = FracBits + 1;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned LinShift  = 31 - FracBits;
  localparam int unsigned ProdW     = LumW + 16;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned DivStages = (RatioW + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned NumLowW   = RatioW - FracBits;

  localparam logic [15:0] WeightR = 16'd13933;
  localparam logic [15:0] WeightG = 16'd46871;
  localparam logic [15:0] WeightB = 16'd4732;

  localparam logic [RatioW-1:0] RatioOne  = RatioW'(1) << FracBits;
  localparam logic [RatioW-1:0] RatioMax  = RatioW'(21) << FracBits;
  localparam logic [RatioW-1:0] BodyReset = RatioW'(9) << (FracBits - 1);
  localparam logic [RatioW-1:0] SecReset  = RatioW'(7) << FracBits;

  typedef enum logic {
    REG_BODY_FLOOR = 1'b0,
    REG_SEC_FLOOR  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] fg_red;
    logic [ChanW-1:0] fg_green;
    logic [ChanW-1:0] fg_blue;
    logic [ChanW-1:0] bg_red;
    logic [ChanW-1:0] bg_green;
    logic [ChanW-1:0] bg_blue;
  } req_t;

  typedef struct packed {
    logic [RatioW-1:0] contrast_ratio;
    logic [LumW-1:0]   fg_luminance;
    logic [LumW-1:0]   bg_luminance;
    logic              meets_body_text;
    logic              meets_security;
  } rsp_t;

  typedef struct packed {
    logic            vld;
    logic [LumW-1:0] r;
    logic [LumW-1:0] g;
    logic [LumW-1:0] b;
  } lin_t;

  typedef struct packed {
    logic              vld;
    logic [RatioW-1:0] rem;
    logic [RatioW-1:0] low;
    logic [RatioW-1:0] quo;
    logic [RatioW-1:0] den;
    logic [LumW-1:0]   lf;
    logic [LumW-1:0]   lb;
  } div_t;

  typedef logic [LumW-1:0] lin_table_t [256];

  function automatic logic [63:0] pow5_q31(logic [63:0] w);
    logic [63:0] w2;
    logic [63:0] w4;
    w2 = (w * w) >> 31;
    w4 = (w2 * w2) >> 31;
    return (w4 * w) >> 31;
  endfunction

  function automatic logic [LumW-1:0] lin_value(logic [63:0] c);
    logic [63:0] one;
    logic [63:0] v;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] w;
    logic [63:0] cand;
    logic [63:0] rnd;
    one = 64'd1 << 31;
    w = 64'd0;
    if (c <= 64'd10) begin
      v = ((64'd100 * c) << 31) / 64'd329460;
    end else begin
      x  = ((64'd1000 * c + 64'd14025) << 31) / 64'd269025;
      x2 = (x * x) >> 31;
      for (int b = 31; b >= 0; b--) begin
        cand = w | (64'd1 << b);
        if (cand <= one && pow5_q31(cand) <= x2) begin
          w = cand;
        end
      end
      if (one <= x2 && pow5_q31(one) <= x2) begin
        w = one;
      end
      v = (x2 * w) >> 31;
    end
    rnd = (v + (64'd1 << (LinShift - 1))) >> LinShift;
    return rnd[LumW-1:0];
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = lin_value(64'(i));
    end
    return t;
  endfunction

  localparam lin_table_t LinTable = build_lin_table();

  function automatic div_t div_step(div_t s);
    div_t o;
    logic [RatioW:0] t;
    o = s;
    t = {s.rem, s.low[RatioW-1]};
    o.low = s.low << 1;
    if (t >= {1'b0, s.den}) begin
      t = t - {1'b0, s.den};
      o.quo = {s.quo[RatioW-2:0], 1'b1};
    end else begin
      o.quo = {s.quo[RatioW-2:0], 1'b0};
    end
    o.rem = t[RatioW-1:0];
    return o;
  endfunction

endpackage

// ===== hdl/ccr_lin_lookup.sv =====
// Registered sRGB to linear lookup for the three channels of one color.
module ccr_lin_lookup (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  logic [ccr_pkg::ChanW-1:0] red_i,
  input  logic [ccr_pkg::ChanW-1:0] green_i,
  input  logic [ccr_pkg::ChanW-1:0] blue_i,
  output ccr_pkg::lin_t            lin_o
);

  ccr_pkg::lin_t lin_d, lin_q;

  always_comb begin
    lin_d.vld = vld_i;
    lin_d.r   = ccr_pkg::LinTable[red_i];
    lin_d.g   = ccr_pkg::LinTable[green_i];
    lin_d.b   = ccr_pkg::LinTable[blue_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q <= '0;
    end else begin
      lin_q <= lin_d;
    end
  end

  assign lin_o = lin_q;

endmodule

// ===== hdl/ccr_luma.sv =====
// Weighted sum of linear channels into relative luminance, two register stages.
module ccr_luma (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ccr_pkg::lin_t             lin_i,
  output logic                      vld_o,
  output logic [ccr_pkg::LumW-1:0]  lum_o
);

  logic                       vld_q;
  logic [ccr_pkg::ProdW-1:0]  pr_q, pg_q, pb_q;
  logic                       sum_vld_q;
  logic [ccr_pkg::LumW-1:0]   lum_q;
  logic [ccr_pkg::SumW-1:0]   sum_d;

  always_comb begin
    sum_d = ccr_pkg::SumW'(pr_q) + ccr_pkg::SumW'(pg_q) + ccr_pkg::SumW'(pb_q)
          + ccr_pkg::SumW'(32768);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      vld_q     <= lin_i.vld;
      sum_vld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q  <= ccr_pkg::ProdW'(lin_i.r) * ccr_pkg::ProdW'(ccr_pkg::WeightR);
    pg_q  <= ccr_pkg::ProdW'(lin_i.g) * ccr_pkg::ProdW'(ccr_pkg::WeightG);
    pb_q  <= ccr_pkg::ProdW'(lin_i.b) * ccr_pkg::ProdW'(ccr_pkg::WeightB);
    lum_q <= sum_d[16 +: ccr_pkg::LumW];
  end

  assign vld_o = sum_vld_q;
  assign lum_o = lum_q;

endmodule

// ===== hdl/ccr_div.sv =====
// Pipelined restoring divider for the contrast ratio, a few quotient bits per stage.
module ccr_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ccr_pkg::div_t div_i,
  output ccr_pkg::div_t div_o
);

  ccr_pkg::div_t stg_d [ccr_pkg::DivStages];
  ccr_pkg::div_t stg_q [ccr_pkg::DivStages];

  always_comb begin
    for (int k = 0; k < ccr_pkg::DivStages; k++) begin
      stg_d[k] = (k == 0) ? div_i : stg_q[(k == 0) ? 0 : k - 1];
      for (int s = 0; s < ccr_pkg::StepsPerStage; s++) begin
        if (k * ccr_pkg::StepsPerStage + s < ccr_pkg::RatioW) begin
          stg_d[k] = ccr_pkg::div_step(stg_d[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ccr_pkg::DivStages; k++) begin
        stg_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < ccr_pkg::DivStages; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign div_o = stg_q[ccr_pkg::DivStages-1];

endmodule

// ===== hdl/color_pair_contrast_ratio.sv =====
// Top level of the color pair contrast ratio block.
// A request carries a foreground and a background sRGB color on req_i and is
// taken at a rising edge with start high; busy stays low, so a new request
// may enter in every cycle and the sustained rate is one request per cycle.
// Each color goes through a table lookup, a weighted sum into luminance, and
// the ratio of the two luminances plus 0.05 is formed by a pipelined divider
// that resolves three quotient bits per stage.
// The result appears on rsp_o with done_o high for exactly one cycle, after
// the lookup, luminance, divider and output registers, in request order. The
// receiver cannot stall the block, and the result is never held.
// The two floors are written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// should change only while no request is in flight.
// Reset clears every valid bit in the pipeline and loads the floors with
// 4.5 for body text and 7.0 for security-critical pairs.
module color_pair_contrast_ratio (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ccr_pkg::req_t               req_i,
  output logic                        done_o,
  output ccr_pkg::rsp_t               rsp_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ccr_pkg::RatioW-1:0]  cfg_wdata_i
);

  logic                         acc;
  ccr_pkg::lin_t                fg_lin, bg_lin;
  logic                         fg_vld, bg_vld;
  logic [ccr_pkg::LumW-1:0]     fg_lum, bg_lum;
  logic [ccr_pkg::LumW-1:0]     hi, lo;
  ccr_pkg::div_t                div_d, div_q, div_out;
  logic [ccr_pkg::RatioW-1:0]   num;
  logic [ccr_pkg::RatioW-1:0]   ratio;
  logic [ccr_pkg::RatioW-1:0]   body_q, sec_q;
  logic                         done_q;
  ccr_pkg::rsp_t                rsp_d, rsp_q;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  ccr_lin_lookup u_fg_lin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (acc),
    .red_i   (req_i.fg_red),
    .green_i (req_i.fg_green),
    .blue_i  (req_i.fg_blue),
    .lin_o   (fg_lin)
  );

  ccr_lin_lookup u_bg_lin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (acc),
    .red_i   (req_i.bg_red),
    .green_i (req_i.bg_green),
    .blue_i  (req_i.bg_blue),
    .lin_o   (bg_lin)
  );

  ccr_luma u_fg_luma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lin_i  (fg_lin),
    .vld_o  (fg_vld),
    .lum_o  (fg_lum)
  );

  ccr_luma u_bg_luma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .lin_i  (bg_lin),
    .vld_o  (bg_vld),
    .lum_o  (bg_lum)
  );

  always_comb begin
    hi  = (fg_lum > bg_lum) ? fg_lum : bg_lum;
    lo  = (fg_lum > bg_lum) ? bg_lum : fg_lum;
    num = ccr_pkg::RatioW'(hi) * ccr_pkg::RatioW'(20) + ccr_pkg::RatioOne;
    div_d.vld = fg_vld && bg_vld;
    div_d.den = ccr_pkg::RatioW'(lo) * ccr_pkg::RatioW'(20) + ccr_pkg::RatioOne;
    div_d.rem = num >> ccr_pkg::NumLowW;
    div_d.low = {num[ccr_pkg::NumLowW-1:0], ccr_pkg::FracBits'(0)};
    div_d.quo = '0;
    div_d.lf  = fg_lum;
    div_d.lb  = bg_lum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else begin
      div_q <= div_d;
    end
  end

  ccr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_q),
    .div_o  (div_out)
  );

  always_comb begin
    priority if (div_out.quo < ccr_pkg::RatioOne) begin
      ratio = ccr_pkg::RatioOne;
    end else if (div_out.quo > ccr_pkg::RatioMax) begin
      ratio = ccr_pkg::RatioMax;
    end else begin
      ratio = div_out.quo;
    end
    rsp_d.contrast_ratio  = ratio;
    rsp_d.fg_luminance    = div_out.lf;
    rsp_d.bg_luminance    = div_out.lb;
    rsp_d.meets_body_text = ratio >= body_q;
    rsp_d.meets_security  = ratio >= sec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= ccr_pkg::BodyReset;
      sec_q  <= ccr_pkg::SecReset;
    end else if (cfg_we_i) begin
      unique case (ccr_pkg::cfg_reg_e'(cfg_idx_i))
        ccr_pkg::REG_BODY_FLOOR: body_q <= cfg_wdata_i;
        ccr_pkg::REG_SEC_FLOOR:  sec_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##12 done_o)
    else $error("A request did not complete after the pipeline latency.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.contrast_ratio >= ccr_pkg::RatioOne &&
                rsp_o.contrast_ratio <= ccr_pkg::RatioMax))
    else $error("Contrast ratio left its range.");

  a_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.fg_luminance == rsp_o.bg_luminance) |->
      rsp_o.contrast_ratio == ccr_pkg::RatioOne)
    else $error("Equal luminances did not give a ratio of one.");

endmodule
